// ===== sv/ilmf_pkg.sv =====
// Package for the IN-list membership filter: sizes, request and answer codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ilmf_pkg;

  localparam int SET_DEPTH = 64;
  localparam int KEY_W     = 64;
  localparam int CNT_W     = $clog2(SET_DEPTH + 1);
  localparam int IDX_W     = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int HELD_W    = 7;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_PROBE  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ANS_FALSE = 2'd0,
    ANS_TRUE  = 2'd1,
    ANS_NULL  = 2'd2
  } ans_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic hit;
    logic scan_end;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/ilmf_ctrl.sv =====
// Controller for the IN-list membership filter: sequences load, key scan and result.
// Depends on ilmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ilmf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ilmf_pkg::sts_t sts,
  output ilmf_pkg::cmd_t     cmd
);

  ilmf_pkg::state_t state_r;
  ilmf_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ilmf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ilmf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ilmf_pkg::ST_EVAL;
        end
      end
      ilmf_pkg::ST_EVAL: begin
        state_nxt = sts.need_scan ? ilmf_pkg::ST_SCAN : ilmf_pkg::ST_FINISH;
      end
      ilmf_pkg::ST_SCAN: begin
        // Stop as soon as a match is seen or every stored key has been compared.
        if (sts.hit || sts.scan_end) begin
          state_nxt = ilmf_pkg::ST_FINISH;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      ilmf_pkg::ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ilmf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ilmf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/ilmf_dpath.sv =====
// Datapath for the IN-list membership filter: item registers, key memory with scan,
// set state, configuration register and output register. Depends on ilmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ilmf_dpath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [1:0]                  in_req_type,
  input  wire logic signed [ilmf_pkg::KEY_W-1:0] in_key,
  input  wire logic                        in_key_is_null,
  input  wire logic                        cfg_wr_en,
  input  wire logic                        cfg_wr_data,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic [1:0]                       out_answer,
  output logic                             out_insert_dropped,
  output logic [ilmf_pkg::HELD_W-1:0]      out_entries_held,
  input  wire ilmf_pkg::cmd_t              cmd,
  output ilmf_pkg::sts_t                   sts
);

  logic [ilmf_pkg::KEY_W-1:0] key_mem [ilmf_pkg::SET_DEPTH];

  ilmf_pkg::req_t             req_r;
  logic [ilmf_pkg::KEY_W-1:0] key_r;
  logic                       key_null_r;
  logic                       list_null_r;
  logic                       list_null_nxt;

  logic [ilmf_pkg::CNT_W-1:0] count_r;
  logic [ilmf_pkg::CNT_W-1:0] count_nxt;
  logic                       has_null_r;
  logic                       has_null_nxt;

  logic [ilmf_pkg::CNT_W-1:0] idx_r;
  logic [ilmf_pkg::CNT_W-1:0] idx_nxt;
  logic                       cmp_vld_r;
  logic                       cmp_vld_nxt;
  logic [ilmf_pkg::KEY_W-1:0] rd_data_r;
  logic                       hit_r;
  logic                       hit_nxt;

  logic                       out_valid_r;
  logic                       out_valid_nxt;
  ilmf_pkg::ans_t             answer_r;
  ilmf_pkg::ans_t             answer_nxt;
  logic                       dropped_r;
  logic                       dropped_nxt;
  logic [ilmf_pkg::HELD_W-1:0] held_r;

  logic scan_issue;
  logic cmp_hit;
  logic set_full;
  logic mem_we;

  assign scan_issue = cmd.scan && (idx_r < count_r);
  assign cmp_hit    = cmp_vld_r && (rd_data_r == key_r);
  assign set_full   = (count_r >= ilmf_pkg::CNT_W'(ilmf_pkg::SET_DEPTH));

  always_comb begin
    sts.need_scan = !key_null_r &&
                    ((req_r == ilmf_pkg::REQ_INSERT) ||
                     ((req_r == ilmf_pkg::REQ_PROBE) && !list_null_r));
    sts.hit       = cmp_hit;
    sts.scan_end  = (idx_r >= count_r) && !cmp_vld_r;
    sts.out_free  = !out_valid_r || out_ready;
  end

  // Item registers are payload and are only loaded on acceptance.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r      <= ilmf_pkg::req_t'(in_req_type);
      key_r      <= in_key;
      key_null_r <= in_key_is_null;
    end
  end

  // The key memory is read one entry a cycle; the compare happens in the cycle after the read.
  always_ff @(posedge clk) begin
    if (scan_issue) begin
      rd_data_r <= key_mem[idx_r[ilmf_pkg::IDX_W-1:0]];
    end
    if (mem_we) begin
      key_mem[count_r[ilmf_pkg::IDX_W-1:0]] <= key_r;
    end
  end

  always_comb begin
    idx_nxt     = idx_r;
    hit_nxt     = hit_r;
    cmp_vld_nxt = scan_issue;
    if (cmd.load) begin
      idx_nxt = '0;
      hit_nxt = 1'b0;
    end else begin
      if (scan_issue) begin
        idx_nxt = idx_r + ilmf_pkg::CNT_W'(1);
      end
      if (cmp_hit) begin
        hit_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    list_null_nxt = cfg_wr_en ? cfg_wr_data : list_null_r;
    count_nxt     = count_r;
    has_null_nxt  = has_null_r;
    answer_nxt    = ilmf_pkg::ANS_FALSE;
    dropped_nxt   = 1'b0;
    mem_we        = 1'b0;
    if (cmd.finish) begin
      case (req_r)
        ilmf_pkg::REQ_CLEAR: begin
          count_nxt    = '0;
          has_null_nxt = 1'b0;
        end
        ilmf_pkg::REQ_INSERT: begin
          if (key_null_r) begin
            has_null_nxt = 1'b1;
          end else if (!hit_r) begin
            if (set_full) begin
              dropped_nxt = 1'b1;
            end else begin
              mem_we    = 1'b1;
              count_nxt = count_r + ilmf_pkg::CNT_W'(1);
            end
          end
        end
        ilmf_pkg::REQ_PROBE: begin
          if (key_null_r || list_null_r) begin
            answer_nxt = ilmf_pkg::ANS_NULL;
          end else if (hit_r) begin
            answer_nxt = ilmf_pkg::ANS_TRUE;
          end else if (has_null_r) begin
            answer_nxt = ilmf_pkg::ANS_NULL;
          end else begin
            answer_nxt = ilmf_pkg::ANS_FALSE;
          end
        end
        default: begin
          answer_nxt = ilmf_pkg::ANS_FALSE;
        end
      endcase
    end
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_null_r <= 1'b0;
      count_r     <= '0;
      has_null_r  <= 1'b0;
      idx_r       <= '0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      list_null_r <= list_null_nxt;
      count_r     <= count_nxt;
      has_null_r  <= has_null_nxt;
      idx_r       <= idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      answer_r  <= answer_nxt;
      dropped_r <= dropped_nxt;
      held_r    <= ilmf_pkg::HELD_W'(count_nxt);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_answer         = answer_r;
  assign out_insert_dropped = dropped_r;
  assign out_entries_held   = held_r;

endmodule

`default_nettype wire

// ===== sv/in_list_membership_filter.sv =====
// IN-list membership filter, top level: joins controller and datapath.
// Depends on ilmf_pkg, ilmf_ctrl and ilmf_dpath.
//
// Use: items on the in_ channel (valid/ready) either clear the set, insert one
// list element, or probe one search term. Every item gives exactly one result
// on the out_ channel (valid/ready): the three-valued answer, a drop flag for
// inserts that found the set full, and the number of distinct keys held.
// cfg_wr_en/cfg_wr_data write the list-is-null flag, which forces every probe
// to answer null; write it only while the block is idle.
// One item is handled at a time. Clears, unused requests, null elements, null
// terms and probes against a null list go straight from evaluation to the
// result. Inserts and probes of a key scan the key memory one entry a cycle;
// a miss compares every stored key, a hit ends the scan at the matching entry.
// The result is valid in the cycle after the item's last working cycle.
// A stalled receiver holds the result in the output register; the block still
// accepts the next item and parks its finished result until the register frees.
// Synchronous reset empties the set, clears the null mark and the config flag;
// key memory contents are not cleared, only the count of valid entries.
`timescale 1ns / 1ps
`default_nettype none

module in_list_membership_filter (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_req_type,
  input  wire logic signed [ilmf_pkg::KEY_W-1:0] in_key,
  input  wire logic                          in_key_is_null,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_answer,
  output logic                               out_insert_dropped,
  output logic [ilmf_pkg::HELD_W-1:0]        out_entries_held,
  input  wire logic                          cfg_wr_en,
  input  wire logic                          cfg_wr_data
);

  ilmf_pkg::cmd_t cmd;
  ilmf_pkg::sts_t sts;

  ilmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ilmf_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_req_type        (in_req_type),
    .in_key             (in_key),
    .in_key_is_null     (in_key_is_null),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_answer         (out_answer),
    .out_insert_dropped (out_insert_dropped),
    .out_entries_held   (out_entries_held),
    .cmd                (cmd),
    .sts                (sts)
  );

`ifndef SYNTHESIS
  // At most one command is issued in any cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.scan, cmd.finish}))
    else $error("more than one datapath command at once");

  // A result is never written over one that the receiver has not yet taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result register overwritten while stalled");

  // An accepted item is evaluated before its result can be produced.
  a_no_early_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !cmd.finish)
    else $error("result produced in the cycle after acceptance");
`endif

endmodule

`default_nettype wire

// ===== dv/ilmf_membership_checker.sv =====
// Membership checker for the IN-list filter: watches both item channels and the
// configuration port, predicts every result and compares it field by field.
// Depends on ilmf_pkg for sizes, request codes and answer codes.
`timescale 1ns / 1ps

module ilmf_membership_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic [1:0]                    in_req_type,
  input  wire logic [ilmf_pkg::KEY_W-1:0]    in_key,
  input  wire logic                          in_key_is_null,
  input  wire logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire logic [1:0]                    out_answer,
  input  wire logic                          out_insert_dropped,
  input  wire logic [ilmf_pkg::HELD_W-1:0]   out_entries_held,
  input  wire logic                          cfg_wr_en,
  input  wire logic                          cfg_wr_data,
  output int unsigned                        fail_count,
  output int unsigned                        outstanding
);

  typedef struct packed {
    ilmf_pkg::ans_t              answer;
    logic                        dropped;
    logic [ilmf_pkg::HELD_W-1:0] held;
  } outcome_t;

  logic [ilmf_pkg::KEY_W-1:0] stored_keys [ilmf_pkg::SET_DEPTH];
  int unsigned      key_total;
  logic             null_element_seen;
  logic             whole_list_null;
  outcome_t         awaited_outcomes [$];
  int unsigned      errors;

  initial begin
    fail_count  = 0;
    outstanding = 0;
    errors      = 0;
  end

  function automatic logic key_present(input logic [ilmf_pkg::KEY_W-1:0] k);
    int i;
    for (i = 0; i < key_total; i++) begin
      if (stored_keys[i] == k) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one item to the shadow set and returns the result it should give.
  function automatic outcome_t filter_outcome(input logic [1:0] req,
                                              input logic [ilmf_pkg::KEY_W-1:0] k,
                                              input logic k_null);
    outcome_t o;
    o.answer  = ilmf_pkg::ANS_FALSE;
    o.dropped = 1'b0;
    case (req)
      ilmf_pkg::REQ_CLEAR: begin
        key_total         = 0;
        null_element_seen = 1'b0;
      end
      ilmf_pkg::REQ_INSERT: begin
        if (k_null) begin
          null_element_seen = 1'b1;
        end else if (!key_present(k)) begin
          if (key_total < ilmf_pkg::SET_DEPTH) begin
            stored_keys[key_total] = k;
            key_total++;
          end else begin
            o.dropped = 1'b1;
          end
        end
      end
      ilmf_pkg::REQ_PROBE: begin
        // A null term or a null list wins before the set is even looked at.
        if (k_null || whole_list_null) o.answer = ilmf_pkg::ANS_NULL;
        else if (key_present(k)) o.answer = ilmf_pkg::ANS_TRUE;
        else if (null_element_seen) o.answer = ilmf_pkg::ANS_NULL;
        else o.answer = ilmf_pkg::ANS_FALSE;
      end
      default: ;
    endcase
    o.held = key_total[ilmf_pkg::HELD_W-1:0];
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (!rst_n) begin
      key_total         = 0;
      null_element_seen = 1'b0;
      whole_list_null   = 1'b0;
      awaited_outcomes.delete();
    end else begin
      // The result leaving at this edge always belongs to an earlier item.
      if (out_valid && out_ready) begin
        got.answer  = ilmf_pkg::ans_t'(out_answer);
        got.dropped = out_insert_dropped;
        got.held    = out_entries_held;
        if (awaited_outcomes.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected result answer %0d dropped %0b held %0d", $realtime,
                     got.answer, got.dropped, got.held);
          errors++;
        end else begin
          want = awaited_outcomes.pop_front();
          if (got.answer !== want.answer || got.dropped !== want.dropped ||
              got.held !== want.held) begin
            if (errors < 10)
              $display({"%0t: mismatch answer exp %0d got %0d, ",
                        "dropped exp %0b got %0b, held exp %0d got %0d"},
                       $realtime, want.answer, got.answer, want.dropped, got.dropped,
                       want.held, got.held);
            errors++;
          end
        end
      end
      if (cfg_wr_en) whole_list_null = cfg_wr_data;
      if (in_valid && in_ready)
        awaited_outcomes.push_back(filter_outcome(in_req_type, in_key, in_key_is_null));
    end
    fail_count  <= errors;
    outstanding <= awaited_outcomes.size();
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top for in_list_membership_filter: clock, reset, stimulus and verdict.
// Depends on ilmf_pkg, the block itself and ilmf_membership_checker.
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0]  REQ_UNUSED   = 2'd3;
  localparam logic [63:0] KEY_MIN      = 64'h8000_0000_0000_0000;
  localparam logic [63:0] KEY_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] KEY_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int          ITEM_TARGET  = 1650;
  localparam int          CYCLE_LIMIT  = 1000000;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [1:0]                  in_req_type = ilmf_pkg::REQ_CLEAR;
  logic [ilmf_pkg::KEY_W-1:0]  in_key = '0;
  logic                        in_key_is_null = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [1:0]                  out_answer;
  logic                        out_insert_dropped;
  logic [ilmf_pkg::HELD_W-1:0] out_entries_held;
  logic                        cfg_wr_en = 1'b0;
  logic                        cfg_wr_data = 1'b0;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned cycles = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  rx_mode_t    rx_mode = RX_ALWAYS;
  int          rx_mode_left = 0;
  logic [63:0] loaded_keys [$];

  in_list_membership_filter uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_key            (in_key),
    .in_key_is_null    (in_key_is_null),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_answer        (out_answer),
    .out_insert_dropped(out_insert_dropped),
    .out_entries_held  (out_entries_held),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  ilmf_membership_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_key            (in_key),
    .in_key_is_null    (in_key_is_null),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_answer        (out_answer),
    .out_insert_dropped(out_insert_dropped),
    .out_entries_held  (out_entries_held),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .fail_count        (fail_count),
    .outstanding       (outstanding)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[in_list_membership_filter] ERROR");
      $finish;
    end
  end

  // The receiver changes its stall habit every so often, including long spells of no stall.
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= rx_mode_t'($urandom_range(0, 3));
      rx_mode_left <= $urandom_range(20, 200);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      RX_ALWAYS: out_ready <= 1'b1;
      RX_COIN:   out_ready <= $urandom_range(0, 1);
      RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
      default:   out_ready <= (cycles[2:0] < 3'd5);
    endcase
  end

  task automatic send_item(input logic [1:0] req, input logic [63:0] k, input logic k_null);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 16);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 80) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_key         <= k;
    in_key_is_null <= k_null;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (req != REQ_UNUSED) items_sent++;
  endtask

  // Waits until every result has come back; the block is then idle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_list_null(input logic v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [63:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        if (loaded_keys.size() > 0) return loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
        return {$urandom, $urandom};
      end
      4, 5: return 64'($urandom_range(0, 8)) - 64'd4;
      6: begin
        case ($urandom_range(0, 3))
          0: return KEY_MIN;
          1: return KEY_MAX;
          2: return '0;
          default: return KEY_ALL_ONES;
        endcase
      end
      7: begin
        // A near miss: one bit away from a key in the list.
        if (loaded_keys.size() > 0)
          return loaded_keys[$urandom_range(0, loaded_keys.size() - 1)] ^
                 (64'd1 << $urandom_range(0, 63));
        return {$urandom, $urandom};
      end
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // One list: set the list-is-null flag, load the list, then mostly probe it.
  task automatic run_list(input int list_len, input logic list_null, input int probes);
    logic [63:0] k;
    logic        n;
    int          roll;
    write_list_null(list_null);
    loaded_keys.delete();
    send_item(ilmf_pkg::REQ_CLEAR, {$urandom, $urandom}, $urandom_range(0, 1));
    for (int i = 0; i < list_len; i++) begin
      k = ($urandom_range(0, 3) == 0) ? pick_key() : {$urandom, $urandom};
      n = ($urandom_range(0, 19) == 0);
      send_item(ilmf_pkg::REQ_INSERT, k, n);
      if (!n) loaded_keys.push_back(k);
    end
    for (int i = 0; i < probes; i++) begin
      roll = $urandom_range(0, 99);
      k    = pick_key();
      if (roll < 82) begin
        send_item(ilmf_pkg::REQ_PROBE, k, ($urandom_range(0, 15) == 0));
      end else if (roll < 93) begin
        n = ($urandom_range(0, 9) == 0);
        send_item(ilmf_pkg::REQ_INSERT, k, n);
        if (!n) loaded_keys.push_back(k);
      end else if (roll < 97) begin
        send_item(REQ_UNUSED, k, $urandom_range(0, 1));
      end else begin
        send_item(ilmf_pkg::REQ_CLEAR, k, $urandom_range(0, 1));
      end
      if (loaded_keys.size() > 96) void'(loaded_keys.pop_front());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    write_list_null(1'b0);
    send_item(ilmf_pkg::REQ_PROBE, '0, 1'b0);
    send_item(ilmf_pkg::REQ_INSERT, KEY_MIN, 1'b0);
    send_item(ilmf_pkg::REQ_INSERT, KEY_MAX, 1'b0);
    send_item(ilmf_pkg::REQ_INSERT, '0, 1'b0);
    send_item(ilmf_pkg::REQ_INSERT, KEY_ALL_ONES, 1'b0);
    send_item(ilmf_pkg::REQ_INSERT, KEY_MAX, 1'b0);
    send_item(ilmf_pkg::REQ_PROBE, KEY_MIN, 1'b0);
    send_item(ilmf_pkg::REQ_PROBE, KEY_MAX, 1'b0);
    send_item(ilmf_pkg::REQ_PROBE, 64'd5, 1'b0);
    send_item(ilmf_pkg::REQ_PROBE, KEY_MAX, 1'b1);
    send_item(ilmf_pkg::REQ_INSERT, 64'd123, 1'b1);
    send_item(ilmf_pkg::REQ_PROBE, 64'd5, 1'b0);
    send_item(ilmf_pkg::REQ_PROBE, KEY_ALL_ONES, 1'b0);
    send_item(REQ_UNUSED, KEY_ALL_ONES, 1'b1);
    send_item(ilmf_pkg::REQ_CLEAR, KEY_ALL_ONES, 1'b0);
    send_item(ilmf_pkg::REQ_PROBE, KEY_MAX, 1'b0);
    write_list_null(1'b1);
    send_item(ilmf_pkg::REQ_PROBE, '0, 1'b0);
    send_item(ilmf_pkg::REQ_INSERT, 64'd7, 1'b0);
    send_item(ilmf_pkg::REQ_PROBE, 64'd7, 1'b0);
    send_item(ilmf_pkg::REQ_CLEAR, '0, 1'b1);
    send_item(ilmf_pkg::REQ_INSERT, 64'd9, 1'b0);
    write_list_null(1'b0);
    send_item(ilmf_pkg::REQ_PROBE, 64'd9, 1'b0);
    send_item(ilmf_pkg::REQ_PROBE, 64'd8, 1'b0);

    // Overfill the set so that new keys are dropped and duplicates still pass.
    run_list(90, 1'b0, 30);

    while (items_sent < ITEM_TARGET) begin
      run_list(($urandom_range(0, 9) == 0) ? $urandom_range(50, 90) : $urandom_range(0, 12),
               ($urandom_range(0, 3) == 0), $urandom_range(10, 60));
    end

    settle();
    if (fail_count == 0) begin
      $display("[in_list_membership_filter] OK");
    end else begin
      $display("[in_list_membership_filter] ERROR");
    end
    $finish;
  end

endmodule
